[hw/rtl/mma_pkg.sv]
// Shared types and constants for the memory-to-memory ALU machine.
// No dependencies; the top level and the ALU import this package.
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;
	localparam int MEM_WORDS = 256;
	localparam int AW = $clog2(MEM_WORDS);
	localparam int WORD_W = 32;
	localparam int CNT_W = $clog2(WORD_W);

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_MUL   = 4'd2,
		CMD_DIV   = 4'd3,
		CMD_POW   = 4'd4,
		CMD_READ  = 4'd5,
		CMD_WRITE = 4'd6,
		CMD_STORE = 4'd7
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_DONE    = 3'd0,
		STAT_EMIT    = 3'd1,
		STAT_BADOP   = 3'd2,
		STAT_DIVZERO = 3'd3,
		STAT_HALTED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC,
		ST_EXEC,
		ST_FIN
	} top_state_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_RUN,
		ALU_PCHK,
		ALU_FIX,
		ALU_DONE
	} alu_state_t;

	typedef struct packed {
		logic start;
		cmd_t op;
	} alu_ctl_t;

	function automatic logic [AW-1:0] addr_of(input logic [7:0] a);
		return AW'(a % MEM_WORDS);
	endfunction
endpackage
`default_nettype wire

[hw/rtl/mma_if.sv]
// Valid/ready channel interfaces for instructions and results.
// Depends on nothing; widths follow the instruction and result fields.
`timescale 1ns / 1ps
`default_nettype none
interface mma_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         cmd;
	logic [7:0]         dest_addr;
	logic signed [31:0] src_a;
	logic [7:0]         src_b_addr;
	logic signed [31:0] read_value;
	modport source(output valid, cmd, dest_addr, src_a, src_b_addr, read_value, input ready);
	modport sink(input valid, cmd, dest_addr, src_a, src_b_addr, read_value, output ready);
endinterface

interface mma_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] out_value;
	modport source(output valid, status, out_value, input ready);
	modport sink(input valid, status, out_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/memory_to_memory_alu_machine_top.sv]
// Top level: instruction decode, data memory with valid bits, result register.
// Depends on mma_pkg, mma_if and mma_alu.
//
// Usage: instructions enter on req (valid/ready), one result per instruction
// leaves on rsp (valid/ready). A transaction is taken when valid and ready
// are both high. req.ready is high only while no instruction is in flight.
// Read, store, write, faulting and halted instructions pass through decode
// and finish into the result register. Add, sub, mul and div also run in the
// one-bit-per-cycle serial unit (32 steps). Power runs one exponent check and
// a 32-step pass per significant exponent bit; a negative exponent skips the
// passes. The result register frees the core: a new instruction is accepted
// while the previous result still waits on a stalled receiver; a second
// result then waits in the core until the register drains.
// Reset clears the valid bits of all 256 words at once, so every word reads
// as zero right away, and clears the halt flag; no clearing pass is needed.
// After a bad opcode every instruction answers ignored until reset.
`timescale 1ns / 1ps
`default_nettype none
module memory_to_memory_alu_machine_top
	import mma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	mma_req_if.sink  req,
	mma_rsp_if.source rsp
);
	top_state_t state_q, state_d;
	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [WORD_W-1:0] rd_a_q, rd_b_q, lit_q, rv_q;
	logic va_q, vb_q;
	logic [3:0] cmd_q;
	logic [AW-1:0] dst_q;
	logic halted_q;
	logic accept;
	logic [AW-1:0] ra_addr, rb_addr;
	logic [WORD_W-1:0] op_a, op_b;
	logic mem_we, set_halt, res_load, out_load;
	logic [WORD_W-1:0] mem_wdata, res_value_d, res_value_q;
	status_t res_status_d, res_status_q;
	alu_ctl_t alu_ctl;
	logic alu_done;
	logic [WORD_W-1:0] alu_res;
	logic out_valid_q;
	status_t out_status_q;
	logic [WORD_W-1:0] out_value_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign ra_addr = (cmd_t'(req.cmd) == CMD_WRITE) ? addr_of(req.dest_addr)
		: addr_of(req.src_a[7:0]);
	assign rb_addr = addr_of(req.src_b_addr);
	assign op_a = va_q ? rd_a_q : '0;
	assign op_b = vb_q ? rd_b_q : '0;

	mma_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (op_a),
		.b      (op_b),
		.done   (alu_done),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wdata = alu_res;
		set_halt = 1'b0;
		res_load = 1'b0;
		res_status_d = STAT_DONE;
		res_value_d = '0;
		alu_ctl = '{start: 1'b0, op: cmd_t'(cmd_q)};
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				res_load = 1'b1;
				state_d = ST_FIN;
				if (halted_q) begin
					res_status_d = STAT_HALTED;
				end else begin
					case (cmd_t'(cmd_q))
						CMD_ADD, CMD_SUB, CMD_MUL, CMD_POW: begin
							alu_ctl.start = 1'b1;
							state_d = ST_EXEC;
						end
						CMD_DIV: begin
							if (op_b == '0) begin
								res_status_d = STAT_DIVZERO;
							end else begin
								alu_ctl.start = 1'b1;
								state_d = ST_EXEC;
							end
						end
						CMD_READ: begin
							mem_we = 1'b1;
							mem_wdata = rv_q;
						end
						CMD_STORE: begin
							mem_we = 1'b1;
							mem_wdata = lit_q;
						end
						CMD_WRITE: begin
							res_status_d = STAT_EMIT;
							res_value_d = op_a;
						end
						default: begin
							res_status_d = STAT_BADOP;
							set_halt = 1'b1;
						end
					endcase
				end
			end
			ST_EXEC: begin
				if (alu_done) begin
					mem_we = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold the result until the output register is free
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			dst_q <= addr_of(req.dest_addr);
			lit_q <= req.src_a;
			rv_q <= req.read_value;
			rd_a_q <= mem[ra_addr];
			rd_b_q <= mem[rb_addr];
		end
		if (mem_we) begin
			mem[dst_q] <= mem_wdata;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_value_q <= res_value_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_value_q <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				va_q <= vld_q[ra_addr];
				vb_q <= vld_q[rb_addr];
			end
			if (mem_we) begin
				vld_q[dst_q] <= 1'b1;
			end
			if (set_halt) begin
				halted_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.out_value = out_value_q;

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag dropped");
	a_no_write_halted: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !halted_q) else $error("memory written while halted");
	a_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == ST_EXEC) else $error("alu finished outside execute");
	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_status_d == STAT_HALTED |-> halted_q)
		else $error("ignored status without halt");
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || rsp.ready) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

[hw/rtl/mma_alu.sv]
// Bit-serial arithmetic unit: add, sub, mul, div and power over 32-bit words.
// Depends on mma_pkg. One multiplier bit, quotient bit or sum bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mma_alu
	import mma_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_ctl_t          ctl,
	input  wire logic [WORD_W-1:0] a,
	input  wire logic [WORD_W-1:0] b,
	output logic                   done,
	output logic [WORD_W-1:0]      result
);
	alu_state_t state_q, state_d;
	cmd_t op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0] sh_x_q, sh_y_q, sh_z_q, p_q, p2_q, rem_q, r_q, bs_q, ex_q, res_q;
	logic c_q, neg_q;
	logic last;
	logic yb, sbit, cout;
	logic [WORD_W:0] rem_sh, rem_n;
	logic ge;
	logic [WORD_W-1:0] p_n, p2_n, a_mag, b_mag, pow_sp;

	assign last = (cnt_q == CNT_W'(WORD_W - 1));
	assign yb = (op_q == CMD_SUB) ? ~sh_y_q[0] : sh_y_q[0];
	assign sbit = sh_x_q[0] ^ yb ^ c_q;
	assign cout = (sh_x_q[0] & yb) | (sh_x_q[0] & c_q) | (yb & c_q);
	assign rem_sh = {rem_q, sh_x_q[WORD_W-1]};
	assign ge = rem_sh >= {1'b0, sh_y_q};
	assign rem_n = ge ? rem_sh - {1'b0, sh_y_q} : rem_sh;
	assign p_n = p_q + (sh_y_q[0] ? sh_x_q : '0);
	assign p2_n = p2_q + (sh_z_q[0] ? sh_x_q : '0);
	assign a_mag = a[WORD_W-1] ? -a : a;
	assign b_mag = b[WORD_W-1] ? -b : b;
	assign pow_sp = (a == WORD_W'(1)) ? WORD_W'(1) :
		(a == '1) ? (b[0] ? '1 : WORD_W'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ALU_IDLE: begin
				if (ctl.start) begin
					if (ctl.op == CMD_POW) begin
						state_d = b[WORD_W-1] ? ALU_DONE : ALU_PCHK;
					end else begin
						state_d = ALU_RUN;
					end
				end
			end
			ALU_RUN: begin
				if (last) begin
					state_d = (op_q == CMD_POW) ? ALU_PCHK : ALU_FIX;
				end
			end
			ALU_PCHK: begin
				state_d = (ex_q == '0) ? ALU_DONE : ALU_RUN;
			end
			ALU_FIX:  state_d = ALU_DONE;
			ALU_DONE: state_d = ALU_IDLE;
			default:  state_d = ALU_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ALU_IDLE: begin
				if (ctl.start) begin
					op_q <= ctl.op;
					cnt_q <= '0;
					p_q <= '0;
					rem_q <= '0;
					c_q <= (ctl.op == CMD_SUB);
					neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
					sh_x_q <= (ctl.op == CMD_DIV) ? a_mag : a;
					sh_y_q <= (ctl.op == CMD_DIV) ? b_mag : b;
					r_q <= WORD_W'(1);
					bs_q <= a;
					ex_q <= b;
					res_q <= pow_sp;
				end
			end
			ALU_RUN: begin
				cnt_q <= cnt_q + CNT_W'(1);
				case (op_q)
					CMD_ADD, CMD_SUB: begin
						p_q <= {sbit, p_q[WORD_W-1:1]};
						c_q <= cout;
						sh_x_q <= sh_x_q >> 1;
						sh_y_q <= sh_y_q >> 1;
					end
					CMD_DIV: begin
						rem_q <= rem_n[WORD_W-1:0];
						sh_x_q <= {sh_x_q[WORD_W-2:0], ge};
					end
					default: begin
						// shift-add multiply; power runs both products at once
						p_q <= p_n;
						p2_q <= p2_n;
						sh_x_q <= sh_x_q << 1;
						sh_y_q <= sh_y_q >> 1;
						sh_z_q <= sh_z_q >> 1;
						if (op_q == CMD_POW && last) begin
							if (ex_q[0]) begin
								r_q <= p_n;
							end
							bs_q <= p2_n;
							ex_q <= ex_q >> 1;
						end
					end
				endcase
			end
			ALU_PCHK: begin
				if (ex_q == '0) begin
					res_q <= r_q;
				end else begin
					cnt_q <= '0;
					p_q <= '0;
					p2_q <= '0;
					sh_x_q <= bs_q;
					sh_y_q <= r_q;
					sh_z_q <= bs_q;
				end
			end
			ALU_FIX: begin
				if (op_q == CMD_DIV) begin
					res_q <= neg_q ? -sh_x_q : sh_x_q;
				end else begin
					res_q <= p_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == ALU_DONE);
	assign result = res_q;
endmodule
`default_nettype wire
